>>> hw/rtl/dbrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual bank record selector package
// Beat types, state type and the status, health, bank and result codes
// shared by the selector's modules.
// ----------------------------------------------------------------------------
package dbrs_pkg;

    // Width of every generation field on the ports.
    localparam int GEN_W = 32;

    // Request modes.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_COMMIT  = 2'd1;
    localparam logic [1:0] MODE_RECOVER = 2'd2;

    // Bank read status codes.
    localparam logic [2:0] ST_MISSING   = 3'd0;
    localparam logic [2:0] ST_VALID     = 3'd1;
    localparam logic [2:0] ST_CORRUPT   = 3'd2;
    localparam logic [2:0] ST_FUTURE    = 3'd3;
    localparam logic [2:0] ST_OVERSIZED = 3'd4;
    localparam logic [2:0] ST_IOERR     = 3'd5;

    // Health codes.
    localparam logic [3:0] H_UNINIT    = 4'd0;
    localparam logic [3:0] H_EMPTY     = 4'd1;
    localparam logic [3:0] H_HEALTHY   = 4'd2;
    localparam logic [3:0] H_RECOVERED = 4'd3;
    localparam logic [3:0] H_DEGRADED  = 4'd4;
    localparam logic [3:0] H_CORRUPT   = 4'd5;
    localparam logic [3:0] H_AMBIGUOUS = 4'd6;
    localparam logic [3:0] H_FUTURE    = 4'd7;
    localparam logic [3:0] H_OVERSIZED = 4'd8;
    localparam logic [3:0] H_UNAVAIL   = 4'd9;
    localparam logic [3:0] H_UNCERTAIN = 4'd10;

    // Bank selectors.
    localparam logic [1:0] BANK_A    = 2'd0;
    localparam logic [1:0] BANK_B    = 2'd1;
    localparam logic [1:0] BANK_NONE = 2'd2;

    // Result codes.
    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_CONFLICT  = 3'd1;
    localparam logic [2:0] RC_RECOVERY  = 3'd2;
    localparam logic [2:0] RC_READ_ONLY = 3'd3;
    localparam logic [2:0] RC_UNAVAIL   = 3'd4;

    typedef struct packed {
        logic [1:0]       mode;
        logic [2:0]       status_a;
        logic [2:0]       status_b;
        logic [GEN_W-1:0] gen_a;
        logic [GEN_W-1:0] gen_b;
        logic             contents_equal;
        logic [GEN_W-1:0] expected_gen;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]       health;
        logic [1:0]       sel_bank;
        logic [GEN_W-1:0] current_gen;
        logic [2:0]       result_code;
        logic             next_write_bank;
        logic             may_mutate;
        logic             may_recover;
        logic             recovery_event;
    } t_out_beat;

    // Selector state other than the generation, whose width is a parameter.
    typedef struct packed {
        logic [3:0] health;
        logic [1:0] active;
        logic [2:0] status_a;
        logic [2:0] status_b;
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/dbrs_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual bank record selector evaluation
// Next state and result beat for one request, from the current state.
// ----------------------------------------------------------------------------
module dbrs_eval #(
    parameter int GEN_BITS = 32
) (
    input  dbrs_pkg::t_state    i_st,
    input  wire [GEN_BITS-1:0]  i_gen,
    input  dbrs_pkg::t_in_beat  i_req,
    output dbrs_pkg::t_state    o_st,
    output logic [GEN_BITS-1:0] o_gen,
    output dbrs_pkg::t_out_beat o_res
);
    import dbrs_pkg::*;

    function automatic logic [2:0] norm_status(input logic [2:0] s, input logic gen_zero);
        logic [2:0] v;
        v = (s > ST_IOERR) ? ST_IOERR : s;
        if (v == ST_VALID && gen_zero) begin
            v = ST_CORRUPT;
        end
        return v;
    endfunction

    function automatic logic allowed(input logic [3:0] h, input logic rec);
        logic ok;
        ok = 1'b0;
        if (h inside {H_EMPTY, H_HEALTHY, H_RECOVERED, H_DEGRADED}) begin
            ok = 1'b1;
        end else if (h inside {H_CORRUPT, H_AMBIGUOUS}) begin
            ok = rec;
        end
        return ok;
    endfunction

    function automatic logic write_target(input t_state s);
        logic t;
        t = 1'b0;
        if (s.active == BANK_A) begin
            t = 1'b1;
        end else if (s.active == BANK_B) begin
            t = 1'b0;
        end else if (s.health == H_DEGRADED && s.status_b == ST_CORRUPT &&
                     s.status_a == ST_MISSING) begin
            t = 1'b1;
        end
        return t;
    endfunction

    logic [GEN_BITS-1:0] ga;
    logic [GEN_BITS-1:0] gb;
    logic [GEN_BITS-1:0] gexp;
    logic [GEN_BITS-1:0] diff;
    logic [GEN_BITS-1:0] gen_inc;
    logic [2:0]          sa;
    logic [2:0]          sb;
    logic                half_apart;
    logic                a_newer;
    logic                rec;
    logic                tgt;
    logic [2:0]          other;
    logic [2:0]          code;
    logic                ev;

    assign ga   = GEN_BITS'(i_req.gen_a);
    assign gb   = GEN_BITS'(i_req.gen_b);
    assign gexp = GEN_BITS'(i_req.expected_gen);
    assign sa   = norm_status(i_req.status_a, ga == '0);
    assign sb   = norm_status(i_req.status_b, gb == '0);

    // Serial-number compare: the difference taken modulo the generation range.
    assign diff       = ga - gb;
    assign half_apart = diff[GEN_BITS-1] && (diff[GEN_BITS-2:0] == '0);
    assign a_newer    = (diff != '0) && !diff[GEN_BITS-1];
    assign gen_inc    = (i_gen + GEN_BITS'(1) == '0) ? GEN_BITS'(1) : i_gen + GEN_BITS'(1);
    assign rec        = (i_req.mode == MODE_RECOVER);
    assign tgt        = write_target(i_st);
    assign other      = tgt ? i_st.status_a : i_st.status_b;

    always_comb begin
        o_st  = i_st;
        o_gen = i_gen;
        code  = RC_OK;
        ev    = 1'b0;
        case (i_req.mode)
            MODE_LOAD: begin
                o_st.status_a = sa;
                o_st.status_b = sb;
                o_st.active   = BANK_NONE;
                o_gen         = '0;
                if (sa == ST_OVERSIZED || sb == ST_OVERSIZED) begin
                    o_st.health = H_OVERSIZED;
                end else if (sa == ST_FUTURE || sb == ST_FUTURE) begin
                    o_st.health = H_FUTURE;
                end else if (sa == ST_VALID && sb == ST_VALID) begin
                    if ((ga == gb && !i_req.contents_equal) || half_apart) begin
                        o_st.health = H_AMBIGUOUS;
                    end else if (ga == gb || a_newer) begin
                        o_st.health = H_HEALTHY;
                        o_st.active = BANK_A;
                        o_gen       = ga;
                    end else begin
                        o_st.health = H_HEALTHY;
                        o_st.active = BANK_B;
                        o_gen       = gb;
                    end
                end else if (sa == ST_VALID) begin
                    o_st.health = H_RECOVERED;
                    o_st.active = BANK_A;
                    o_gen       = ga;
                    ev          = (sb != ST_MISSING);
                end else if (sb == ST_VALID) begin
                    o_st.health = H_RECOVERED;
                    o_st.active = BANK_B;
                    o_gen       = gb;
                    ev          = (sa != ST_MISSING);
                end else if (sa == ST_MISSING && sb == ST_MISSING) begin
                    o_st.health = H_EMPTY;
                end else if ((sa == ST_MISSING && sb == ST_CORRUPT) ||
                             (sb == ST_MISSING && sa == ST_CORRUPT)) begin
                    o_st.health = H_DEGRADED;
                    ev          = 1'b1;
                end else if (sa == ST_IOERR || sb == ST_IOERR) begin
                    o_st.health = H_UNAVAIL;
                end else begin
                    o_st.health = H_CORRUPT;
                end
            end
            MODE_COMMIT, MODE_RECOVER: begin
                if (!allowed(i_st.health, rec)) begin
                    if (i_st.health == H_CORRUPT || i_st.health == H_AMBIGUOUS) begin
                        code = RC_RECOVERY;
                    end else if (i_st.health == H_UNAVAIL) begin
                        code = RC_UNAVAIL;
                    end else begin
                        code = RC_READ_ONLY;
                    end
                end else if (gexp != i_gen) begin
                    code = RC_CONFLICT;
                end else if (rec && (i_st.health == H_CORRUPT ||
                                     i_st.health == H_AMBIGUOUS)) begin
                    // Both banks are rewritten at the recovery generation.
                    o_st.status_a = ST_VALID;
                    o_st.status_b = ST_VALID;
                    o_st.health   = H_HEALTHY;
                    o_st.active   = BANK_A;
                    o_gen         = GEN_BITS'(1);
                end else begin
                    if (tgt) begin
                        o_st.status_b = ST_VALID;
                        o_st.active   = BANK_B;
                    end else begin
                        o_st.status_a = ST_VALID;
                        o_st.active   = BANK_A;
                    end
                    o_st.health = (other == ST_VALID) ? H_HEALTHY : H_RECOVERED;
                    o_gen       = gen_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.health          = o_st.health;
        o_res.sel_bank        = o_st.active;
        o_res.current_gen     = GEN_W'(o_gen);
        o_res.result_code     = code;
        o_res.next_write_bank = write_target(o_st);
        o_res.may_mutate      = allowed(o_st.health, 1'b0);
        o_res.may_recover     = allowed(o_st.health, 1'b1);
        o_res.recovery_event  = ev;
    end

endmodule
`default_nettype wire

>>> hw/rtl/dual_bank_record_selector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Dual bank record selector unit
// Tracks the health, active bank and generation of an A/B pair of records.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (i_in_valid, i_in, o_in_stall) carries one beat per
// load evaluation, verified commit or verified recovery commit. Every
// request beat produces exactly one response beat on the response channel
// (o_out_valid, o_out, i_out_stall), in request order.
// The state update and the response are computed in the cycle a request
// beat is accepted; the response goes to the output register, or to the
// skid register while that is held. One request is taken per cycle while
// o_in_stall is low; the single compare-and-select pass loops state to state.
// When the receiver stalls, the held response stays in the output register
// and one more response lands in a skid register; only when the skid is full
// does o_in_stall rise. o_in_stall is registered and never depends on inputs.
// Synchronous reset clears both registers' valid bits and returns the state
// to uninitialized health, no active bank and generation zero.
// ----------------------------------------------------------------------------
module dual_bank_record_selector_unit #(
    parameter int GEN_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  dbrs_pkg::t_in_beat  i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dbrs_pkg::t_out_beat o_out,
    input  wire                 i_out_stall
);
    import dbrs_pkg::*;

    // Selector state.
    t_state              r_st;
    t_state              n_st;
    logic [GEN_BITS-1:0] r_gen;
    logic [GEN_BITS-1:0] n_gen;

    // Response for the beat being accepted this cycle.
    t_out_beat n_res;

    // Output register and skid register.
    logic      r_out_valid;
    t_out_beat r_out;
    logic      r_skid_valid;
    t_out_beat r_skid;

    logic in_fire;
    logic out_free;

    dbrs_eval #(
        .GEN_BITS(GEN_BITS)
    ) u_eval (
        .i_st  (r_st),
        .i_gen (r_gen),
        .i_req (i_in),
        .o_st  (n_st),
        .o_gen (n_gen),
        .o_res (n_res)
    );

    // The request side is held off only while the skid register is occupied.
    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // State advances on every accepted request beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.health   <= H_UNINIT;
            r_st.active   <= BANK_NONE;
            r_st.status_a <= ST_MISSING;
            r_st.status_b <= ST_MISSING;
            r_gen         <= '0;
        end else if (in_fire) begin
            r_st  <= n_st;
            r_gen <= n_gen;
        end
    end

    // Output stage with skid: a response that cannot move into a busy output
    // register waits in the skid register and is drained first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (!out_free && in_fire) begin
            r_skid <= n_res;
        end
    end

`ifndef SYNTH
    // The skid register only fills behind a held response.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    // A stalled response with a filled skid must not be overwritten.
    a_held_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_skid_valid) |=> (r_out == $past(r_out)))
        else $error("held response changed under stall");

    // Nothing published means generation zero.
    a_none_gen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.sel_bank == BANK_NONE) |-> (o_out.current_gen == '0))
        else $error("generation published without an active bank");

    // Any health that admits ordinary changes also admits recovery changes.
    a_mutate_implies_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.may_mutate) |-> o_out.may_recover)
        else $error("mutation allowed where recovery is not");
`endif

endmodule
`default_nettype wire

>>> sim/dual_bank_record_selector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual bank record selector unit testbench
// Sends load evaluations, verified commits and recovery commits to the
// selector. A shadow copy of the selector state predicts every response
// beat, and each response is compared field by field in arrival order.
// Traffic runs back to back, with sender gaps, with receiver stalls and with
// both.
// ----------------------------------------------------------------------------
module dual_bank_record_selector_unit_test;
    import dbrs_pkg::*;

    // The unused request mode and the two status codes above io error.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] ST_CODE6   = 3'd6;
    localparam logic [2:0] ST_CODE7   = 3'd7;

    localparam logic [GEN_W-1:0] GEN_HALF     = {1'b1, {(GEN_W-1){1'b0}}};
    localparam logic [GEN_W-1:0] GEN_TOP      = '1;
    localparam logic [GEN_W-1:0] RECOVERY_GEN = 1;

    localparam int RANDOM_BEATS  = 385;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_beat  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out;
    logic      i_out_stall;

    dual_bank_record_selector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // Shadow of the selector state, advanced once per accepted request beat.
    logic [3:0]       shadow_health;
    logic [1:0]       shadow_bank;
    logic [GEN_W-1:0] shadow_gen;
    logic [2:0]       shadow_stat_a;
    logic [2:0]       shadow_stat_b;

    // Predicted responses, oldest first.
    t_out_beat pending_responses[$];

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned error_count     = 0;
    int unsigned beats_checked   = 0;
    int unsigned loads_sent      = 0;
    int unsigned commits_done    = 0;
    int unsigned recoveries_done = 0;
    int unsigned cycle_count     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Codes above io error read as io error, and a valid record can never
    // carry generation zero, so such a bank counts as corrupt.
    function automatic logic [2:0] clean_status(logic [2:0] raw, logic [GEN_W-1:0] gen);
        logic [2:0] s;
        s = (raw > ST_IOERR) ? ST_IOERR : raw;
        if (s == ST_VALID && gen == '0) begin
            s = ST_CORRUPT;
        end
        return s;
    endfunction

    function automatic bit commit_allowed(bit recovery);
        case (shadow_health)
            H_EMPTY, H_HEALTHY, H_RECOVERED, H_DEGRADED: return 1'b1;
            H_CORRUPT, H_AMBIGUOUS: return recovery;
            default: return 1'b0;
        endcase
    endfunction

    // A commit goes to the bank opposite the active one. With no active bank
    // it goes to A, except in degraded health when B is the corrupt one.
    function automatic logic commit_target();
        if (shadow_bank == BANK_A) return 1'b1;
        if (shadow_bank == BANK_B) return 1'b0;
        if (shadow_health == H_DEGRADED && shadow_stat_b == ST_CORRUPT &&
                shadow_stat_a == ST_MISSING) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void set_shadow(logic [3:0] h, logic [1:0] bank, logic [GEN_W-1:0] g);
        shadow_health = h;
        shadow_bank   = bank;
        shadow_gen    = g;
    endfunction

    // Load evaluation. Returns the recovery flag of the response.
    function automatic logic apply_load(t_in_beat b);
        logic [2:0]       sa;
        logic [2:0]       sb;
        logic [GEN_W-1:0] diff;
        logic             recovered;
        sa = clean_status(b.status_a, b.gen_a);
        sb = clean_status(b.status_b, b.gen_b);
        diff = b.gen_a - b.gen_b;
        recovered = 1'b0;
        shadow_stat_a = sa;
        shadow_stat_b = sb;
        if (sa == ST_OVERSIZED || sb == ST_OVERSIZED) begin
            set_shadow(H_OVERSIZED, BANK_NONE, '0);
        end else if (sa == ST_FUTURE || sb == ST_FUTURE) begin
            set_shadow(H_FUTURE, BANK_NONE, '0);
        end else if (sa == ST_VALID && sb == ST_VALID) begin
            // Serial-number compare: a forward distance below half the range
            // means A is newer, exactly half is ambiguous.
            if (diff == '0) begin
                if (b.contents_equal) begin
                    set_shadow(H_HEALTHY, BANK_A, b.gen_a);
                end else begin
                    set_shadow(H_AMBIGUOUS, BANK_NONE, '0);
                end
            end else if (diff == GEN_HALF) begin
                set_shadow(H_AMBIGUOUS, BANK_NONE, '0);
            end else if (diff < GEN_HALF) begin
                set_shadow(H_HEALTHY, BANK_A, b.gen_a);
            end else begin
                set_shadow(H_HEALTHY, BANK_B, b.gen_b);
            end
        end else if (sa == ST_VALID) begin
            set_shadow(H_RECOVERED, BANK_A, b.gen_a);
            recovered = (sb != ST_MISSING);
        end else if (sb == ST_VALID) begin
            set_shadow(H_RECOVERED, BANK_B, b.gen_b);
            recovered = (sa != ST_MISSING);
        end else if (sa == ST_MISSING && sb == ST_MISSING) begin
            set_shadow(H_EMPTY, BANK_NONE, '0);
        end else if ((sa == ST_MISSING && sb == ST_CORRUPT) ||
                     (sb == ST_MISSING && sa == ST_CORRUPT)) begin
            set_shadow(H_DEGRADED, BANK_NONE, '0);
            recovered = 1'b1;
        end else if (sa == ST_IOERR || sb == ST_IOERR) begin
            set_shadow(H_UNAVAIL, BANK_NONE, '0);
        end else begin
            set_shadow(H_CORRUPT, BANK_NONE, '0);
        end
        return recovered;
    endfunction

    // Verified commit or recovery commit. Returns the result code.
    function automatic logic [2:0] apply_commit(bit recovery, logic [GEN_W-1:0] want);
        logic [GEN_W-1:0] next_gen;
        logic             tgt;
        logic [2:0]       other;
        if (!commit_allowed(recovery)) begin
            if (shadow_health == H_CORRUPT || shadow_health == H_AMBIGUOUS) return RC_RECOVERY;
            if (shadow_health == H_UNAVAIL) return RC_UNAVAIL;
            return RC_READ_ONLY;
        end
        if (want != shadow_gen) return RC_CONFLICT;
        if (recovery && (shadow_health == H_CORRUPT || shadow_health == H_AMBIGUOUS)) begin
            shadow_stat_a = ST_VALID;
            shadow_stat_b = ST_VALID;
            set_shadow(H_HEALTHY, BANK_A, RECOVERY_GEN);
            return RC_OK;
        end
        // The generation wraps past zero straight to one.
        next_gen = shadow_gen + 1'b1;
        if (next_gen == '0) begin
            next_gen = 1;
        end
        tgt = commit_target();
        if (tgt) begin
            shadow_stat_b = ST_VALID;
            other = shadow_stat_a;
        end else begin
            shadow_stat_a = ST_VALID;
            other = shadow_stat_b;
        end
        set_shadow((other == ST_VALID) ? H_HEALTHY : H_RECOVERED, {1'b0, tgt}, next_gen);
        return RC_OK;
    endfunction

    function automatic t_out_beat predict_response(t_in_beat b);
        t_out_beat r;
        r = '0;
        case (b.mode)
            MODE_LOAD:    r.recovery_event = apply_load(b);
            MODE_COMMIT:  r.result_code = apply_commit(1'b0, b.expected_gen);
            MODE_RECOVER: r.result_code = apply_commit(1'b1, b.expected_gen);
            default: ;
        endcase
        r.health          = shadow_health;
        r.sel_bank        = shadow_bank;
        r.current_gen     = shadow_gen;
        r.next_write_bank = commit_target();
        r.may_mutate      = commit_allowed(1'b0);
        r.may_recover     = commit_allowed(1'b1);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic t_in_beat build_request(logic [1:0] mode, logic [2:0] sa, logic [2:0] sb,
                                               logic [GEN_W-1:0] ga, logic [GEN_W-1:0] gb,
                                               logic eq, logic [GEN_W-1:0] want);
        t_in_beat b;
        b.mode           = mode;
        b.status_a       = sa;
        b.status_b       = sb;
        b.gen_a          = ga;
        b.gen_b          = gb;
        b.contents_equal = eq;
        b.expected_gen   = want;
        return b;
    endfunction

    // Sends one request beat and records its predicted response once the
    // beat is taken. Idle cycles come first so valid never drops while a
    // beat waits under stall.
    task automatic send_request(input t_in_beat b);
        t_out_beat predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predicted = predict_response(b);
        pending_responses.push_back(predicted);
        if (b.mode == MODE_LOAD) loads_sent++;
        if (b.mode == MODE_COMMIT && predicted.result_code == RC_OK) commits_done++;
        if (b.mode == MODE_RECOVER && predicted.result_code == RC_OK) recoveries_done++;
    endtask

    // Holds the sender off until every predicted response has come back.
    task automatic wait_for_responses();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_responses.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                   input logic [GEN_W-1:0] want);
        error_count++;
        $display("[%0t] response %0d: %s got 0x%0h, predicted 0x%0h",
                 $time, beats_checked, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [GEN_W-1:0] got,
                               input logic [GEN_W-1:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Every response beat taken is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected response beat", o_out.health, '0);
            end else begin
                want = pending_responses.pop_front();
                check_field("health", o_out.health, want.health);
                check_field("sel_bank", o_out.sel_bank, want.sel_bank);
                check_field("current_gen", o_out.current_gen, want.current_gen);
                check_field("result_code", o_out.result_code, want.result_code);
                check_field("next_write_bank", o_out.next_write_bank, want.next_write_bank);
                check_field("may_mutate", o_out.may_mutate, want.may_mutate);
                check_field("may_recover", o_out.may_recover, want.may_recover);
                check_field("recovery_event", o_out.recovery_event, want.recovery_event);
            end
            beats_checked++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles, %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Fresh out of reset, then the unused mode and the out-of-range statuses.
    task automatic test_reserved_codes();
        // Uninitialized health refuses commits as read only.
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        // The unused mode with every other bit set changes nothing.
        send_request(build_request(MODE_SPARE, ST_CODE7, ST_CODE7, GEN_TOP, GEN_TOP, 1'b1,
                                   GEN_TOP));
        // A status above io error reads as io error, not as a missing bank.
        send_request(build_request(MODE_LOAD, ST_CODE6, ST_MISSING, GEN_TOP, '0, 1'b0, '0));
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
    endtask

    task automatic test_bank_selection();
        send_request(build_request(MODE_LOAD, ST_FUTURE, ST_VALID, '0, 4, 1'b0, '0));
        send_request(build_request(MODE_LOAD, ST_OVERSIZED, ST_FUTURE, 3, 3, 1'b1, '0));
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, 10, 20, 1'b0, '0));
        // Generation one is newer than the top value across the wrap.
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, 1, GEN_TOP, 1'b0, '0));
        // Exactly half the range apart cannot be ordered.
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, 5, 5 + GEN_HALF, 1'b1, '0));
        // Equal generations need equal contents to be trusted.
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, 7, 7, 1'b0, '0));
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, 7, 7, 1'b1, '0));
    endtask

    task automatic test_commit_flow();
        send_request(build_request(MODE_LOAD, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        // A stale expected generation is a conflict.
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, 5));
        send_request(build_request(MODE_LOAD, ST_VALID, ST_VALID, GEN_TOP, GEN_TOP - 1, 1'b0,
                                   '0));
        // The next generation after the top value skips zero.
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, GEN_TOP));
        // In a healthy store a recovery commit is an ordinary commit.
        send_request(build_request(MODE_RECOVER, ST_MISSING, ST_MISSING, '0, '0, 1'b0, 1));
    endtask

    task automatic test_recovery_paths();
        // A valid bank at generation zero counts as corrupt: degraded store.
        send_request(build_request(MODE_LOAD, ST_VALID, ST_MISSING, '0, 9, 1'b0, '0));
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        // Corrupt bank B with A missing steers the next commit to B.
        send_request(build_request(MODE_LOAD, ST_MISSING, ST_CORRUPT, '0, '0, 1'b0, '0));
        send_request(build_request(MODE_RECOVER, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        send_request(build_request(MODE_LOAD, ST_VALID, ST_CORRUPT, 9, 2, 1'b0, '0));
        send_request(build_request(MODE_LOAD, ST_MISSING, ST_VALID, '0, 3, 1'b0, '0));
        send_request(build_request(MODE_LOAD, ST_CORRUPT, ST_CORRUPT, 4, 4, 1'b1, '0));
        // Only a recovery commit may rewrite a corrupt store.
        send_request(build_request(MODE_COMMIT, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
        send_request(build_request(MODE_RECOVER, ST_MISSING, ST_MISSING, '0, '0, 1'b0, '0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    function automatic logic [GEN_W-1:0] pick_gen();
        case ($urandom_range(9))
            0: return '0;
            1: return GEN_TOP;
            2: return GEN_HALF;
            3: return GEN_HALF - 1;
            4: return 1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_status();
        if ($urandom_range(99) < 50) return ST_VALID;
        return 3'($urandom_range(7));
    endfunction

    // Loads, commits and recovery commits, most naming the live generation, so
    // commit chains build up; the rest name another generation or use the spare mode.
    function automatic t_in_beat random_request();
        t_in_beat    b;
        int unsigned roll;
        b.status_a       = pick_status();
        b.status_b       = pick_status();
        b.gen_a          = pick_gen();
        b.contents_equal = 1'($urandom_range(1));
        case ($urandom_range(5))
            0: b.gen_b = b.gen_a;
            1: b.gen_b = b.gen_a ^ GEN_HALF;
            2: b.gen_b = b.gen_a + GEN_W'($urandom_range(1, 3));
            3: b.gen_b = b.gen_a - GEN_W'($urandom_range(1, 3));
            default: b.gen_b = pick_gen();
        endcase
        roll = $urandom_range(99);
        if (roll < 80) begin
            b.expected_gen = shadow_gen;
        end else if (roll < 88) begin
            b.expected_gen = shadow_gen + 1'b1;
        end else begin
            b.expected_gen = pick_gen();
        end
        roll = $urandom_range(99);
        if (roll < 40) begin
            b.mode = MODE_LOAD;
        end else if (roll < 72) begin
            b.mode = MODE_COMMIT;
        end else if (roll < 96) begin
            b.mode = MODE_RECOVER;
        end else begin
            b.mode = MODE_SPARE;
        end
        return b;
    endfunction

    task automatic test_random_traffic(input int unsigned sender_idle, input int unsigned rx_stall);
        idle_pct  = sender_idle;
        stall_pct = rx_stall;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            send_request(random_request());
        end
        wait_for_responses();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        // The shadow starts where reset leaves the selector.
        shadow_health = H_UNINIT;
        shadow_bank   = BANK_NONE;
        shadow_gen    = '0;
        shadow_stat_a = ST_MISSING;
        shadow_stat_b = ST_MISSING;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reserved_codes();
        test_bank_selection();
        test_commit_flow();
        test_recovery_paths();
        wait_for_responses();

        test_random_traffic(0, 0);
        test_random_traffic(51, 0);
        test_random_traffic(0, 51);
        test_random_traffic(8, 8);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_responses.size() != 0) begin
            report_mismatch("responses never returned", pending_responses.size(), '0);
        end
        $display("Checked %0d response beats: %0d loads, %0d commits and %0d recovery commits",
                 beats_checked, loads_sent, commits_done, recoveries_done);
        $display("ran back to back, with sender gaps, with receiver stalls and both, in %0d cycles.",
                 cycle_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
